[rtl/cpa_pkg.sv]
// Shared types and constants of the contiguous page allocator.
package cpa_pkg;

  localparam int unsigned CfgW    = 11;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned StatusW = 3;

  localparam logic [CfgW-1:0] CountMax = 11'd2047;

  localparam logic CfgPagesInUse = 1'b0;
  localparam logic CfgReserved   = 1'b1;

  localparam logic [CfgW-1:0] PagesInUseRst = 11'd1024;
  localparam logic [CfgW-1:0] ReservedRst   = 11'd1;

  typedef enum logic [1:0] {
    FN_INIT       = 2'd0,
    FN_ALLOC      = 2'd1,
    FN_FREE_BLOCK = 2'd2,
    FN_FREE_PAGE  = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK          = 3'd0,
    STS_OUT_OF_MEM  = 3'd1,
    STS_NOT_INIT    = 3'd2,
    STS_NOT_FOUND   = 3'd3,
    STS_PART_OF_SET = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PG_FREE  = 2'd0,
    PG_FIXED = 2'd1,
    PG_USED  = 2'd2
  } pg_e;

  typedef struct packed {
    pg_e  pstate;
    logic tail;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_ALLOC_SCAN,
    S_ALLOC_WRITE,
    S_FREE_SCAN,
    S_FPAGE_READ,
    S_FPAGE_CHECK
  } state_e;

endpackage

[rtl/contiguous_page_allocator.sv]
// First-fit contiguous page allocator built around a page map RAM.
// After reset the page map is cleared, one page per cycle, with busy high.
// Init writes every page of the map; allocate scans from page 0 for the first free run of the
// requested length and then marks its pages used; free block frees pages until a tail ends
// the block or the managed count is reached; free page frees a page only if it is a tail.
// The single RAM port pair sets the pace; done_o marks a one-cycle result that cannot stall.
module contiguous_page_allocator
  import cpa_pkg::*;
#(
  parameter int unsigned MAP_PAGES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [CfgW-1:0]    request_pages_i,
  input  logic [IndexW-1:0]  page_index_i,
  output logic               done_o,
  output logic [StatusW-1:0] status_o,
  output logic [IndexW-1:0]  alloc_index_o,
  output logic [CfgW-1:0]    used_pages_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  localparam int unsigned AW   = $clog2(MAP_PAGES);
  localparam int unsigned CmpW = (AW > CfgW) ? AW : CfgW;
  localparam logic [AW-1:0]   LastPage = AW'(MAP_PAGES - 1);
  localparam logic [CfgW-1:0] NumCap   =
      (MAP_PAGES > 2047) ? CountMax : CfgW'(MAP_PAGES);

  state_e state_q, state_d;

  logic [CfgW-1:0]  pages_in_use_q, reserved_q;
  logic [CfgW-1:0]  used_q, used_d;
  logic             init_q, init_d;
  logic [CfgW-1:0]  scan_q, scan_d;
  logic [CfgW-1:0]  proc_q, proc_d;
  logic             pend_q, pend_d;
  logic [CfgW-1:0]  run_q, run_d;
  logic [CfgW-1:0]  n_q, n_d;
  logic [CfgW-1:0]  res_q, res_d;
  logic [AW-1:0]    sweep_q, sweep_d;
  logic [CfgW-1:0]  wr_q, wr_d;
  logic [CfgW-1:0]  last_q, last_d;
  logic [IndexW-1:0] first_q, first_d;
  logic             done_q, done_d;
  status_e          status_q, status_d;
  logic [IndexW-1:0] alloc_q, alloc_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t            ent;

  logic [CfgW-1:0] pc;
  logic            accept;
  logic            idx_out;
  logic            scan_more;
  logic [CfgW-1:0] run_inc;
  logic            hit;
  logic            scan_end;
  logic            fb_stop;
  logic            sweep_last;
  logic            wr_last;
  logic [CfgW-1:0] used_dec;
  logic [CfgW:0]   used_sum;
  logic [CfgW-1:0] first_full;

  cpa_ram #(
    .Width($bits(entry_t)),
    .Depth(MAP_PAGES)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(AW'(scan_q)),
    .rdata_o(ram_rdata)
  );

  assign ent        = entry_t'(ram_rdata);
  assign pc         = (pages_in_use_q < NumCap) ? pages_in_use_q : NumCap;
  assign busy       = (state_q != S_IDLE);
  assign accept     = start && !busy;
  assign idx_out    = ({1'b0, page_index_i} >= pc);
  assign scan_more  = (scan_q < pc);
  assign run_inc    = (ent.pstate == PG_FREE) ? run_q + 11'd1 : '0;
  assign hit        = pend_q && (run_inc == n_q);
  assign scan_end   = !pend_q && !scan_more;
  assign fb_stop    = pend_q && ent.tail;
  assign sweep_last = (sweep_q == LastPage);
  assign wr_last    = (wr_q == last_q);
  assign used_dec   = (used_q != '0) ? used_q - 11'd1 : used_q;
  assign used_sum   = {1'b0, used_q} + {1'b0, n_q};
  assign first_full = proc_q + 11'd1 - n_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (func_e'(func_i))
            FN_INIT:       state_d = init_q ? S_IDLE : S_INIT;
            FN_ALLOC:      state_d = (used_q >= pc || !init_q) ? S_IDLE : S_ALLOC_SCAN;
            FN_FREE_BLOCK: state_d = idx_out ? S_IDLE : S_FREE_SCAN;
            FN_FREE_PAGE:  state_d = idx_out ? S_IDLE : S_FPAGE_READ;
          endcase
        end
      end
      S_INIT: begin
        if (sweep_last) state_d = S_IDLE;
      end
      S_ALLOC_SCAN: begin
        if (hit) begin
          state_d = S_ALLOC_WRITE;
        end else if (scan_end) begin
          state_d = S_IDLE;
        end
      end
      S_ALLOC_WRITE: begin
        if (wr_last) state_d = S_IDLE;
      end
      S_FREE_SCAN: begin
        if (fb_stop || scan_end) state_d = S_IDLE;
      end
      S_FPAGE_READ:  state_d = S_FPAGE_CHECK;
      S_FPAGE_CHECK: state_d = S_IDLE;
      default:       state_d = S_IDLE;
    endcase
  end

  always_comb begin
    used_d    = used_q;
    init_d    = init_q;
    scan_d    = scan_q;
    proc_d    = proc_q;
    pend_d    = pend_q;
    run_d     = run_q;
    n_d       = n_q;
    res_d     = res_q;
    sweep_d   = sweep_q;
    wr_d      = wr_q;
    last_d    = last_q;
    first_d   = first_q;
    done_d    = 1'b0;
    status_d  = status_q;
    alloc_d   = alloc_q;
    ram_we    = 1'b0;
    ram_waddr = sweep_q;
    ram_wdata = '{pstate: PG_FREE, tail: 1'b0};

    unique case (state_q)
      S_CLEAR: begin
        ram_we  = 1'b1;
        sweep_d = sweep_q + AW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          n_d     = (request_pages_i == '0) ? 11'd1 : request_pages_i;
          res_d   = (reserved_q < pc) ? reserved_q : pc;
          sweep_d = '0;
          pend_d  = 1'b0;
          run_d   = '0;
          alloc_d = '0;
          unique case (func_e'(func_i))
            FN_INIT: begin
              if (init_q) begin
                done_d   = 1'b1;
                status_d = STS_OK;
              end
            end
            FN_ALLOC: begin
              scan_d = '0;
              if (used_q >= pc) begin
                done_d   = 1'b1;
                status_d = STS_OUT_OF_MEM;
              end else if (!init_q) begin
                done_d   = 1'b1;
                status_d = STS_NOT_INIT;
              end
            end
            FN_FREE_BLOCK, FN_FREE_PAGE: begin
              scan_d = {1'b0, page_index_i};
              if (idx_out) begin
                done_d   = 1'b1;
                status_d = STS_NOT_FOUND;
              end
            end
          endcase
        end
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '{pstate: (CmpW'(sweep_q) < CmpW'(res_q)) ? PG_FIXED : PG_FREE,
                      tail: 1'b0};
        sweep_d   = sweep_q + AW'(1);
        if (sweep_last) begin
          used_d   = res_q;
          init_d   = 1'b1;
          done_d   = 1'b1;
          status_d = STS_OK;
        end
      end
      S_ALLOC_SCAN: begin
        pend_d = scan_more;
        proc_d = scan_q;
        if (scan_more) scan_d = scan_q + 11'd1;
        if (pend_q) run_d = run_inc;
        if (hit) begin
          wr_d    = first_full;
          first_d = first_full[IndexW-1:0];
          last_d  = proc_q;
          used_d  = used_sum[CfgW] ? CountMax : used_sum[CfgW-1:0];
        end else if (scan_end) begin
          done_d   = 1'b1;
          status_d = STS_OUT_OF_MEM;
        end
      end
      S_ALLOC_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(wr_q);
        ram_wdata = '{pstate: PG_USED, tail: wr_last};
        wr_d      = wr_q + 11'd1;
        if (wr_last) begin
          done_d   = 1'b1;
          status_d = STS_OK;
          alloc_d  = first_q;
        end
      end
      S_FREE_SCAN: begin
        pend_d = scan_more;
        proc_d = scan_q;
        if (scan_more) scan_d = scan_q + 11'd1;
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(proc_q);
          used_d    = used_dec;
        end
        if (fb_stop || scan_end) begin
          done_d   = 1'b1;
          status_d = STS_OK;
        end
      end
      S_FPAGE_READ: begin
      end
      S_FPAGE_CHECK: begin
        done_d = 1'b1;
        if (ent.tail) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(scan_q);
          used_d    = used_dec;
          status_d  = STS_OK;
        end else begin
          status_d  = STS_PART_OF_SET;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_in_use_q <= PagesInUseRst;
      reserved_q     <= ReservedRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPagesInUse: pages_in_use_q <= cfg_wdata_i;
        CfgReserved:   reserved_q     <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      used_q   <= '0;
      init_q   <= 1'b0;
      scan_q   <= '0;
      proc_q   <= '0;
      pend_q   <= 1'b0;
      run_q    <= '0;
      n_q      <= '0;
      res_q    <= '0;
      sweep_q  <= '0;
      wr_q     <= '0;
      last_q   <= '0;
      first_q  <= '0;
      done_q   <= 1'b0;
      status_q <= STS_OK;
      alloc_q  <= '0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      init_q   <= init_d;
      scan_q   <= scan_d;
      proc_q   <= proc_d;
      pend_q   <= pend_d;
      run_q    <= run_d;
      n_q      <= n_d;
      res_q    <= res_d;
      sweep_q  <= sweep_d;
      wr_q     <= wr_d;
      last_q   <= last_d;
      first_q  <= first_d;
      done_q   <= done_d;
      status_q <= status_d;
      alloc_q  <= alloc_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign alloc_index_o = alloc_q;
  assign used_pages_o  = used_q;

endmodule

[rtl/cpa_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module cpa_ram #(
  parameter int unsigned Width = 3,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
